// ----- hw/rtl/sde_pkg.sv -----
// Shared types and constants for the sorted dictionary encoder.
// Used by every module of the block; depends on nothing else.
package sde_pkg;

    // Default sizes of the dictionary store.
    localparam int DICT_DEPTH_DEF = 64;
    localparam int KEY_WIDTH_DEF  = 32;

    // Depths of the internal queues.
    localparam int CMD_Q_DEPTH  = 2;
    localparam int RES_Q_DEPTH  = 4;

    // Operation codes of an input word.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } op_e;

    // Search predicate codes.
    localparam logic [2:0] PRED_EQ = 3'd0;
    localparam logic [2:0] PRED_NE = 3'd1;
    localparam logic [2:0] PRED_LT = 3'd2;
    localparam logic [2:0] PRED_LE = 3'd3;
    localparam logic [2:0] PRED_GT = 3'd4;
    localparam logic [2:0] PRED_GE = 3'd5;

    // Input word as seen on the ports.
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] key;
        logic [2:0]         predicate;
        logic [5:0]         lookup_code;
        logic               bulk;
    } in_word_t;

    // Result word as seen on the ports.
    typedef struct packed {
        logic [5:0]         code;
        logic               hit;
        logic signed [31:0] entry_value;
        logic               renumber;
        logic               full_res;
        logic               last;
    } out_word_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        op_e         op;
        logic [31:0] key;
        logic [2:0]  predicate;
        logic [5:0]  lookup_code;
        logic        bulk;
    } cmd_t;

endpackage

// ----- hw/rtl/sde_front.sv -----
// Front end of the sorted dictionary encoder: accepts input words, decodes
// them and queues commands for the back end. Depends on sde_pkg.
module sde_front
    import sde_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_word_t item,
    output logic     full,
    output cmd_t     cmd,
    output logic     cmd_valid,
    input  logic     cmd_take
);

    localparam int QW = $clog2(CMD_Q_DEPTH);
    localparam int NW = $clog2(CMD_Q_DEPTH + 1);

    cmd_t            q_reg [CMD_Q_DEPTH];
    logic [QW-1:0]   wp_reg, wp_next;
    logic [QW-1:0]   rp_reg, rp_next;
    logic [NW-1:0]   cnt_reg, cnt_next;
    cmd_t            dec;
    logic            keep;
    logic            acc;
    logic            take;

    // Decode the input word; unknown operations are dropped here.
    always_comb
    begin
        dec.key         = item.key;
        dec.predicate   = item.predicate;
        dec.lookup_code = item.lookup_code;
        dec.bulk        = item.bulk;
        unique case (item.op)
            2'd0:    dec.op = OP_INSERT;
            2'd1:    dec.op = OP_SEARCH;
            2'd2:    dec.op = OP_LOOKUP;
            default: dec.op = OP_NONE;
        endcase
        keep = (dec.op != OP_NONE);
    end

    assign full      = (cnt_reg == NW'(CMD_Q_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rp_reg];
    assign acc       = push && !full && keep;
    assign take      = cmd_take && cmd_valid;

    // Queue pointers and fill count.
    always_comb
    begin
        wp_next  = acc  ? QW'(wp_reg + 1'b1) : wp_reg;
        rp_next  = take ? QW'(rp_reg + 1'b1) : rp_reg;
        cnt_next = cnt_reg;
        if (acc && !take)
        begin
            cnt_next = NW'(cnt_reg + 1'b1);
        end
        else if (!acc && take)
        begin
            cnt_next = NW'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[wp_reg] <= dec;
        end
    end

endmodule

// ----- hw/rtl/sde_res_fifo.sv -----
// Result queue of the sorted dictionary encoder; its read side is the
// result port of the block. Depends on sde_pkg.
module sde_res_fifo
    import sde_pkg::*;
#(
    parameter int DEPTH = RES_Q_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  out_word_t wdata,
    output logic      full,
    output out_word_t rdata,
    output logic      empty,
    input  logic      pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    out_word_t      buf_reg [DEPTH];
    logic [PW-1:0]  wp_reg;
    logic [PW-1:0]  rp_reg;
    logic [NW-1:0]  cnt_reg;
    logic           do_wr;
    logic           do_rd;

    assign full  = (cnt_reg == NW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = buf_reg[rp_reg];
    assign do_wr = wr && !full;
    assign do_rd = pop && !empty;

    // Pointers wrap at the depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : PW'(wp_reg + 1'b1);
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : PW'(rp_reg + 1'b1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= NW'(cnt_reg + 1'b1);
            end
            else if (!do_wr && do_rd)
            begin
                cnt_reg <= NW'(cnt_reg - 1'b1);
            end
        end
    end

    // Word storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            buf_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ----- hw/rtl/sde_back.sv -----
// Back end of the sorted dictionary encoder: holds the key store and runs
// scans, shifts and result emission. Depends on sde_pkg.
module sde_back
    import sde_pkg::*;
#(
    parameter int DICT_DEPTH = DICT_DEPTH_DEF,
    parameter int KEY_WIDTH  = KEY_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sorted_mode,
    input  cmd_t      cmd,
    input  logic      cmd_valid,
    output logic      cmd_take,
    output out_word_t res,
    output logic      res_push,
    input  logic      res_full
);

    localparam int AW = $clog2(DICT_DEPTH);
    localparam int CW = $clog2(DICT_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DICT_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_PUT,
        S_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        SK_LB,
        SK_EQF,
        SK_EMIT,
        SK_PRED
    } scan_t;

    // Key store with one write port and one registered read port.
    logic [KEY_WIDTH-1:0] mem [DICT_DEPTH];
    logic [KEY_WIDTH-1:0] rd_data_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [KEY_WIDTH-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;

    state_t               state_reg, state_next;
    scan_t                kind_reg, kind_next;
    op_e                  op_reg, op_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [2:0]           pred_reg, pred_next;
    logic                 bulk_reg, bulk_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        rd_idx_reg, rd_idx_next;
    logic [CW-1:0]        end_reg, end_next;
    logic                 have_reg, have_next;
    logic [CW-1:0]        ev_idx_reg, ev_idx_next;
    logic                 skip_en_reg, skip_en_next;
    logic [CW-1:0]        skip_idx_reg, skip_idx_next;
    logic [CW-1:0]        lb_reg, lb_next;
    logic                 eq_reg, eq_next;
    logic                 pend_valid_reg, pend_valid_next;
    out_word_t            pend_reg, pend_next;
    logic [CW-1:0]        sh_rd_reg, sh_rd_next;
    logic                 sh_more_reg, sh_more_next;
    logic                 wr_pend_reg, wr_pend_next;
    logic [CW-1:0]        wr_addr_reg, wr_addr_next;

    logic                 ev_lt;
    logic                 ev_eq;
    logic                 pred_ok;
    logic                 emit;
    logic                 stop;
    logic                 new_res;
    logic                 stall;
    logic                 lc_hit;
    logic [CW-1:0]        lc_idx;
    logic [CW-1:0]        lb_eq;

    // Compare the entry just read against the command key.
    assign ev_lt  = $signed(rd_data_reg) < $signed(key_reg);
    assign ev_eq  = (rd_data_reg == key_reg);
    assign lc_hit = (CW + 6)'(cmd.lookup_code) < (CW + 6)'(count_reg);
    assign lc_idx = CW'(cmd.lookup_code);
    assign lb_eq  = CW'(lb_reg + CW'(eq_reg));

    // Predicate applied to a stored entry in arrival-order mode.
    always_comb
    begin
        case (pred_reg)
            PRED_EQ: pred_ok = ev_eq;
            PRED_NE: pred_ok = !ev_eq;
            PRED_LT: pred_ok = ev_lt;
            PRED_LE: pred_ok = ev_lt || ev_eq;
            PRED_GT: pred_ok = !ev_lt && !ev_eq;
            PRED_GE: pred_ok = !ev_lt;
            default: pred_ok = 1'b0;
        endcase
    end

    // What the current scan does with the entry under evaluation.
    always_comb
    begin
        case (kind_reg)
            SK_LB:
            begin
                emit = 1'b0;
                stop = !ev_lt;
            end
            SK_EQF:
            begin
                emit = 1'b0;
                stop = ev_eq;
            end
            SK_EMIT:
            begin
                emit = !(skip_en_reg && (ev_idx_reg == skip_idx_reg));
                stop = 1'b0;
            end
            default:
            begin
                emit = pred_ok;
                stop = pred_ok && (pred_reg == PRED_EQ);
            end
        endcase
    end

    assign new_res = have_reg && emit;
    assign stall   = new_res && pend_valid_reg && res_full;

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pred_next       = pred_reg;
        bulk_next       = bulk_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        end_next        = end_reg;
        have_next       = have_reg;
        ev_idx_next     = ev_idx_reg;
        skip_en_next    = skip_en_reg;
        skip_idx_next   = skip_idx_reg;
        lb_next         = lb_reg;
        eq_next         = eq_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        sh_rd_next      = sh_rd_reg;
        sh_more_next    = sh_more_reg;
        wr_pend_next    = wr_pend_reg;
        wr_addr_next    = wr_addr_reg;
        cmd_take        = 1'b0;
        res_push        = 1'b0;
        res             = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = key_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take        = 1'b1;
                    op_next         = cmd.op;
                    key_next        = KEY_WIDTH'($unsigned(cmd.key));
                    pred_next       = cmd.predicate;
                    bulk_next       = cmd.bulk;
                    rd_idx_next     = '0;
                    end_next        = count_reg;
                    have_next       = 1'b0;
                    skip_en_next    = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = S_SCAN;
                    case (cmd.op)
                        OP_INSERT: kind_next = sorted_mode ? SK_LB : SK_EQF;
                        OP_SEARCH: kind_next = sorted_mode ? SK_LB : SK_PRED;
                        default:
                        begin
                            kind_next   = SK_EMIT;
                            rd_idx_next = lc_hit ? lc_idx : '0;
                            end_next    = lc_hit ? CW'(lc_idx + 1'b1) : '0;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (!stall)
                begin
                    // Hold the newest match back so the final one can carry last.
                    if (new_res)
                    begin
                        if (pend_valid_reg)
                        begin
                            res_push = 1'b1;
                            res      = pend_reg;
                        end
                        pend_next             = '0;
                        pend_next.code        = 6'(ev_idx_reg);
                        pend_next.hit         = 1'b1;
                        pend_next.entry_value = 32'($signed(rd_data_reg));
                        pend_valid_next       = 1'b1;
                    end
                    if (have_reg && stop)
                    begin
                        have_next  = 1'b0;
                        lb_next    = ev_idx_reg;
                        eq_next    = (kind_reg == SK_LB) ? ev_eq : 1'b1;
                        state_next = (kind_reg == SK_PRED) ? S_FLUSH : S_DECIDE;
                    end
                    else if (rd_idx_reg < end_reg)
                    begin
                        mem_re      = 1'b1;
                        mem_raddr   = rd_idx_reg[AW-1:0];
                        have_next   = 1'b1;
                        ev_idx_next = rd_idx_reg;
                        rd_idx_next = CW'(rd_idx_reg + 1'b1);
                    end
                    else
                    begin
                        have_next = 1'b0;
                        if (!have_reg)
                        begin
                            if ((kind_reg == SK_LB) || (kind_reg == SK_EQF))
                            begin
                                lb_next    = count_reg;
                                eq_next    = 1'b0;
                                state_next = S_DECIDE;
                            end
                            else
                            begin
                                state_next = S_FLUSH;
                            end
                        end
                    end
                end
            end

            S_DECIDE:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (eq_reg)
                    begin
                        // Key already present: report its code.
                        pend_next             = '0;
                        pend_next.code        = 6'(lb_reg);
                        pend_next.hit         = 1'b1;
                        pend_next.entry_value = 32'($signed(key_reg));
                        pend_valid_next       = 1'b1;
                        state_next            = S_FLUSH;
                    end
                    else if (count_reg == DEPTH_C)
                    begin
                        pend_next          = '0;
                        pend_next.full_res = 1'b1;
                        pend_valid_next    = 1'b1;
                        state_next         = S_FLUSH;
                    end
                    else if (lb_reg < count_reg)
                    begin
                        sh_rd_next   = CW'(count_reg - 1'b1);
                        sh_more_next = 1'b1;
                        wr_pend_next = 1'b0;
                        state_next   = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    // Ordered search: one range around the lower bound, NE minus key.
                    kind_next     = SK_EMIT;
                    have_next     = 1'b0;
                    skip_en_next  = (pred_reg == PRED_NE) && eq_reg;
                    skip_idx_next = lb_reg;
                    state_next    = S_SCAN;
                    case (pred_reg)
                        PRED_EQ:
                        begin
                            rd_idx_next = lb_reg;
                            end_next    = lb_eq;
                        end
                        PRED_NE:
                        begin
                            rd_idx_next = '0;
                            end_next    = count_reg;
                        end
                        PRED_LT:
                        begin
                            rd_idx_next = '0;
                            end_next    = lb_reg;
                        end
                        PRED_LE:
                        begin
                            rd_idx_next = '0;
                            end_next    = lb_eq;
                        end
                        PRED_GT:
                        begin
                            rd_idx_next = lb_eq;
                            end_next    = count_reg;
                        end
                        PRED_GE:
                        begin
                            rd_idx_next = lb_reg;
                            end_next    = count_reg;
                        end
                        default:
                        begin
                            state_next = S_FLUSH;
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // Move entries up by one, from the top down to the insert point.
                if (wr_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_addr_reg[AW-1:0];
                    mem_wdata = rd_data_reg;
                end
                if (sh_more_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = sh_rd_reg[AW-1:0];
                    wr_pend_next = 1'b1;
                    wr_addr_next = CW'(sh_rd_reg + 1'b1);
                    if (sh_rd_reg == lb_reg)
                    begin
                        sh_more_next = 1'b0;
                    end
                    else
                    begin
                        sh_rd_next = CW'(sh_rd_reg - 1'b1);
                    end
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg)
                    begin
                        state_next = S_PUT;
                    end
                end
            end

            S_PUT:
            begin
                mem_we                = 1'b1;
                mem_waddr             = lb_reg[AW-1:0];
                mem_wdata             = key_reg;
                count_next            = CW'(count_reg + 1'b1);
                pend_next             = '0;
                pend_next.code        = 6'(lb_reg);
                pend_next.hit         = 1'b1;
                pend_next.entry_value = 32'($signed(key_reg));
                pend_next.renumber    = !bulk_reg && (lb_reg < count_reg);
                pend_valid_next       = 1'b1;
                state_next            = S_FLUSH;
            end

            S_FLUSH:
            begin
                // Final word of the command, or one no-hit word.
                if (!res_full)
                begin
                    res_push        = 1'b1;
                    res             = pend_valid_reg ? pend_reg : '0;
                    res.last        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= SK_LB;
            op_reg         <= OP_INSERT;
            key_reg        <= '0;
            pred_reg       <= '0;
            bulk_reg       <= 1'b0;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            end_reg        <= '0;
            have_reg       <= 1'b0;
            ev_idx_reg     <= '0;
            skip_en_reg    <= 1'b0;
            skip_idx_reg   <= '0;
            lb_reg         <= '0;
            eq_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            sh_rd_reg      <= '0;
            sh_more_reg    <= 1'b0;
            wr_pend_reg    <= 1'b0;
            wr_addr_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            pred_reg       <= pred_next;
            bulk_reg       <= bulk_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            end_reg        <= end_next;
            have_reg       <= have_next;
            ev_idx_reg     <= ev_idx_next;
            skip_en_reg    <= skip_en_next;
            skip_idx_reg   <= skip_idx_next;
            lb_reg         <= lb_next;
            eq_reg         <= eq_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            sh_rd_reg      <= sh_rd_next;
            sh_more_reg    <= sh_more_next;
            wr_pend_reg    <= wr_pend_next;
            wr_addr_reg    <= wr_addr_next;
        end
    end

    // Key store access.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // The store never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above store depth");

    // A result is only pushed when the result queue has room.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    // Each write in the put state adds exactly one entry.
    a_put_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |=> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("entry count not advanced by an insert");

    // Shifted entries only land above the insert point.
    a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && wr_pend_reg) |-> (wr_addr_reg > lb_reg))
        else $error("shift write at or below the insert point");

endmodule

// ----- hw/rtl/sorted_dictionary_encoder_core.sv -----
// Top level of the sorted dictionary encoder: front end, back end, result
// queue and the mode register. Depends on sde_pkg and the sde_ modules.
//
// An input word goes into a two-deep command queue; the back end then runs it
// against a key store with one write and one read port, reading one entry per
// cycle while the result queue has room. An insert scans for its place (the
// lower-bound position, or the entry count in arrival-order mode) and then, in
// ordered mode, shifts the later entries up. An ordered-mode search scans up to
// the lower bound, then reads out the matching codes; a lookup reads at most one
// entry. Results wait in a four-word queue, so the back end keeps running while
// the reader stalls until it fills. The store needs no clearing after reset.
module sorted_dictionary_encoder_core
    import sde_pkg::*;
#(
    parameter int DICT_DEPTH = DICT_DEPTH_DEF,
    parameter int KEY_WIDTH  = KEY_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_word_t  item,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output out_word_t result,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    logic      sorted_mode_reg;
    cmd_t      cmd;
    logic      cmd_valid;
    logic      cmd_take;
    out_word_t res_word;
    logic      res_push;
    logic      res_full;

    // Ordering mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sorted_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            sorted_mode_reg <= cfg_wdata;
        end
    end

    sde_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take)
    );

    sde_back #(
        .DICT_DEPTH (DICT_DEPTH),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .sorted_mode (sorted_mode_reg),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid),
        .cmd_take    (cmd_take),
        .res         (res_word),
        .res_push    (res_push),
        .res_full    (res_full)
    );

    sde_res_fifo #(
        .DEPTH (RES_Q_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_push),
        .wdata (res_word),
        .full  (res_full),
        .rdata (result),
        .empty (empty),
        .pop   (pop)
    );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the sorted dictionary encoder core.
// Depends on sde_pkg and sorted_dictionary_encoder_core; a small class predicts results.
module tb_top;
    import sde_pkg::*;

    localparam int DEPTH       = 64;
    localparam int STALL_LIMIT = 20000;

    // Predicts result words of the dictionary and holds the expected ones.
    class dict_scoreboard;
        logic [31:0] keys[DEPTH];
        int          count;
        bit          ordered;
        out_word_t   pending[$];
        int          errors;
        int          words_checked;

        function new();
            count = 0;
            ordered = 1;
            errors = 0;
            words_checked = 0;
        endfunction

        // Signed compare via flipped sign bit.
        function automatic logic [31:0] biased(logic [31:0] k);
            return k ^ 32'h8000_0000;
        endfunction

        function automatic void add_word(int pos, bit hit, bit ren, bit fl);
            out_word_t w;
            w = '0;
            w.hit = hit;
            w.code = hit ? pos[5:0] : 6'd0;
            w.entry_value = (hit && pos < count) ? keys[pos] : 32'd0;
            w.renumber = ren;
            w.full_res = fl;
            pending = {pending, w};
        endfunction

        function automatic int first_not_below(logic [31:0] k);
            int i;
            for (i = 0; i < count; i++)
                if (biased(keys[i]) >= biased(k))
                    return i;
            return count;
        endfunction

        function automatic bit pred_ok(logic [31:0] e, logic [31:0] k, logic [2:0] p);
            logic [31:0] be;
            logic [31:0] bk;
            be = biased(e);
            bk = biased(k);
            case (p)
                PRED_EQ: return be == bk;
                PRED_NE: return be != bk;
                PRED_LT: return be < bk;
                PRED_LE: return be <= bk;
                PRED_GT: return be > bk;
                PRED_GE: return be >= bk;
                default: return 0;
            endcase
        endfunction

        // Note an accepted input word and queue its expected results.
        function automatic void note_input(in_word_t w);
            int prior_size;
            int i;
            int pos;
            bit done;
            prior_size = pending.size();
            done = 0;
            case (w.op)
                OP_INSERT:
                begin
                    if (!ordered)
                    begin
                        for (i = 0; i < count && !done; i++)
                            if (keys[i] == w.key)
                            begin
                                add_word(i, 1, 0, 0);
                                done = 1;
                            end
                        if (!done)
                        begin
                            if (count >= DEPTH)
                                add_word(0, 0, 0, 1);
                            else
                            begin
                                keys[count] = w.key;
                                count++;
                                add_word(count - 1, 1, 0, 0);
                            end
                        end
                    end
                    else
                    begin
                        pos = first_not_below(w.key);
                        if (pos < count && keys[pos] == w.key)
                            add_word(pos, 1, 0, 0);
                        else if (count >= DEPTH)
                            add_word(0, 0, 0, 1);
                        else
                        begin
                            for (i = count; i > pos; i--)
                                keys[i] = keys[i - 1];
                            keys[pos] = w.key;
                            count++;
                            add_word(pos, 1, !w.bulk && (pos + 1 < count), 0);
                        end
                    end
                end
                OP_SEARCH:
                begin
                    if (!ordered || w.predicate > PRED_GE)
                    begin
                        for (i = 0; i < count && !done; i++)
                            if (pred_ok(keys[i], w.key, w.predicate))
                            begin
                                add_word(i, 1, 0, 0);
                                if (w.predicate == PRED_EQ)
                                    done = 1;
                            end
                    end
                    else
                    begin
                        // Ordered mode: ranges around the lower bound, even if unordered.
                        int lb;
                        int lo;
                        int hi;
                        int eqpos;
                        bit eq;
                        lb = first_not_below(w.key);
                        eq = lb < count && keys[lb] == w.key;
                        eqpos = eq ? lb : count;
                        case (w.predicate)
                            PRED_EQ: begin lo = lb; hi = eq ? lb + 1 : lb; end
                            PRED_NE: begin lo = 0; hi = count; end
                            PRED_LT: begin lo = 0; hi = lb; end
                            PRED_LE: begin lo = 0; hi = eq ? lb + 1 : lb; end
                            PRED_GT: begin lo = eq ? lb + 1 : lb; hi = count; end
                            default: begin lo = lb; hi = count; end
                        endcase
                        for (i = lo; i < hi; i++)
                            if (!(w.predicate == PRED_NE && i == eqpos))
                                add_word(i, 1, 0, 0);
                    end
                    if (pending.size() == prior_size)
                        add_word(0, 0, 0, 0);
                end
                OP_LOOKUP:
                    add_word(w.lookup_code, w.lookup_code < count, 0, 0);
                default:
                    ;
            endcase
            if (pending.size() > prior_size)
                pending[pending.size() - 1].last = 1;
        endfunction

        // Compare one accepted result word with the oldest expectation.
        function automatic void check_result(out_word_t got);
            out_word_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            words_checked++;
            if (got.code !== exp.code)
            begin
                $error("code: expected %0d, got %0d", exp.code, got.code);
                errors++;
            end
            if (got.hit !== exp.hit)
            begin
                $error("hit: expected %0d, got %0d", exp.hit, got.hit);
                errors++;
            end
            if (got.entry_value !== exp.entry_value)
            begin
                $error("entry_value: expected %0d, got %0d", exp.entry_value,
                       got.entry_value);
                errors++;
            end
            if (got.renumber !== exp.renumber)
            begin
                $error("renumber: expected %0d, got %0d", exp.renumber, got.renumber);
                errors++;
            end
            if (got.full_res !== exp.full_res)
            begin
                $error("full_res: expected %0d, got %0d", exp.full_res, got.full_res);
                errors++;
            end
            if (got.last !== exp.last)
            begin
                $error("last: expected %0d, got %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      push;
    in_word_t  item;
    logic      full;
    logic      empty;
    logic      pop;
    out_word_t result;
    logic      cfg_we;
    logic      cfg_wdata;

    dict_scoreboard board;
    bit  src_idle_on;
    bit  sink_idle_on;
    int  quiet_cycles;
    int  words_sent;
    logic [31:0] recent_keys[$];

    sorted_dictionary_encoder_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Result side: random stall bursts, checks on every accepted word.
    initial
    begin
        int burst;
        pop = 0;
        board = new();
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                board.check_result(result);
            if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 16);
                pop <= 0;
                repeat (burst) @(posedge clk);
                pop <= 1;
            end
            else
                pop <= 1;
        end
    end

    // Watchdog: cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_we)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Send one word; held until accepted, with random gaps before it.
    task automatic send_word(in_word_t w);
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            push <= 0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        push <= 1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_input(w);
        words_sent++;
    endtask

    task automatic wait_drained();
        push <= 0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_mode(bit mode);
        wait_drained();
        cfg_we <= 1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 0;
        board.ordered = mode;
    endtask

    function automatic in_word_t make_word(op_e op, logic [31:0] k, logic [2:0] p,
                                           logic [5:0] lc, bit bk);
        in_word_t w;
        w.op = op;
        w.key = k;
        w.predicate = p;
        w.lookup_code = lc;
        w.bulk = bk;
        return w;
    endfunction

    // Keys from a narrow range, recent inserts, the extremes or fully random, so hits are common.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return recent_keys.size() ? recent_keys[$urandom_range(0,
                   recent_keys.size() - 1)] : 32'd0;
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $signed($urandom_range(0, 80)) - 40;
        endcase
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        w = make_word(op_e'($urandom_range(0, 2)), pick_key(), 3'($urandom_range(0, 7)),
                      6'($urandom()), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 40) == 0)
            w.op = OP_NONE;
        if (w.op == OP_INSERT)
            recent_keys = {recent_keys, w.key};
        if (recent_keys.size() > 40)
            void'(recent_keys.pop_front());
        return w;
    endfunction

    initial
    begin
        int i;
        int p;
        push = 0;
        item = '0;
        cfg_we = 0;
        cfg_wdata = 0;
        rst_n = 0;
        src_idle_on = 1;
        sink_idle_on = 1;
        words_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty store, extremes, duplicates, every predicate, bad codes.
        send_word(make_word(OP_SEARCH, 32'd5, PRED_EQ, 6'd0, 0));
        send_word(make_word(OP_LOOKUP, 32'd0, PRED_EQ, 6'd0, 0));
        send_word(make_word(OP_INSERT, 32'h7fff_ffff, PRED_EQ, 6'd0, 0));
        send_word(make_word(OP_INSERT, 32'h8000_0000, PRED_EQ, 6'd0, 0));
        send_word(make_word(OP_INSERT, 32'd0, PRED_EQ, 6'd0, 1));
        send_word(make_word(OP_INSERT, 32'd0, PRED_EQ, 6'd0, 0));
        send_word(make_word(OP_INSERT, 32'hffff_ffff, PRED_EQ, 6'd0, 0));
        for (p = 0; p < 8; p++)
            send_word(make_word(OP_SEARCH, 32'd0, 3'(p), 6'd0, 0));
        send_word(make_word(OP_LOOKUP, 32'd0, PRED_EQ, 6'd3, 0));
        send_word(make_word(OP_LOOKUP, 32'd0, PRED_EQ, 6'd63, 0));
        send_word(make_word(OP_NONE, 32'hffff_ffff, 3'd7, 6'h3f, 1));

        // Unordered appends on top of ordered entries.
        write_mode(0);
        send_word(make_word(OP_INSERT, 32'd7, PRED_EQ, 6'd0, 0));
        send_word(make_word(OP_INSERT, 32'hffff_fff0, PRED_EQ, 6'd0, 0));
        send_word(make_word(OP_SEARCH, 32'd7, PRED_EQ, 6'd0, 0));
        send_word(make_word(OP_SEARCH, 32'd0, PRED_NE, 6'd0, 0));
        write_mode(1);
        send_word(make_word(OP_SEARCH, 32'd1, PRED_GE, 6'd0, 0));

        // Random phases, mode set at random between them; the store fills and refuses.
        for (i = 0; i < 460; i++)
        begin
            if (i % 115 == 114)
                write_mode(1'($urandom_range(0, 1)));
            if (i >= 400)
            begin
                src_idle_on = 0;
                sink_idle_on = 0;
            end
            send_word(random_word());
        end
        push <= 0;

        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d input words, checked %0d result words over both modes,",
                 words_sent, board.words_checked);
        $display("with a full store, %0d entries at the end.", board.count);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/sde_pkg.sv
hw/rtl/sde_front.sv
hw/rtl/sde_res_fifo.sv
hw/rtl/sde_back.sv
hw/rtl/sorted_dictionary_encoder_core.sv
bench/tb_top.sv
